// ===== hw/rtl/bode_stability_margin_scan_macros.svh =====
// Assertion helpers for the margin scan.
`ifndef BODE_STABILITY_MARGIN_SCAN_MACROS_SVH
`define BODE_STABILITY_MARGIN_SCAN_MACROS_SVH
`ifndef SYNTHESIS
`define BSMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsms: implication check failed");
`define BSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsms: next-cycle check failed");
`else
`define BSMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bsms_pkg.sv =====
package bsms_pkg;

  localparam int FreqW     = 40;
  localparam int MagW      = 17;
  localparam int PhaseW    = 20;
  localparam int ValW      = FreqW + 1;
  localparam int NdW       = PhaseW + 1;
  localparam int MagnW     = PhaseW;
  localparam int UfW       = FreqW;
  localparam int ProdW     = MagnW + UfW;
  localparam int MulSteps  = MagnW;
  localparam int DivSteps  = ProdW;
  localparam int StepCntW  = $clog2(DivSteps);
  localparam int InTdataW  = 80;
  localparam int OutTdataW = 120;
  localparam int OutTuserW = 2;
  localparam int PmWideW   = PhaseW + 2;
  localparam int GmWideW   = MagW + 1;

  localparam logic [PhaseW-1:0]  PhaseThresh = 20'hF4C00;
  localparam logic [PmWideW-1:0] PhaseOffset = 22'd46080;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_G_FREQ,
    ST_G_PH,
    ST_P_FREQ,
    ST_P_MAG,
    ST_COMMIT
  } bsms_state_e;

  typedef enum logic [2:0] {
    IU_IDLE,
    IU_ABS,
    IU_MUL,
    IU_BIAS,
    IU_DIV,
    IU_FIN
  } bsms_iu_state_e;

  typedef struct packed {
    logic            start;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [NdW-1:0]  n;
    logic [NdW-1:0]  d;
  } bsms_iu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bsms_iu_stat_t;

endpackage

// ===== hw/rtl/bsms_interp.sv =====
module bsms_interp import bsms_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsms_iu_req_t    req_i,
  output bsms_iu_stat_t   stat_o,
  output logic [ValW-1:0] res_o
);

  bsms_iu_state_e      state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [ValW-1:0]     a_q, a_d;
  logic [ValW:0]       diff_q, diff_d;
  logic                neg_q, neg_d;
  logic [MagnW-1:0]    ud_q, ud_d;
  logic [UfW-1:0]      uf_q, uf_d;
  logic [MagnW-1:0]    rem_q, rem_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [ValW-1:0]     res_q, res_d;

  logic [ValW:0]       diff_w;
  logic [ValW:0]       diff_neg;
  logic [NdW-1:0]      n_neg;
  logic [NdW-1:0]      d_neg;
  logic [MagnW-1:0]    n_abs;
  logic [MagnW-1:0]    d_abs;
  logic [UfW:0]        hi;
  logic [MagnW:0]      trial;
  logic [MagnW:0]      trial_sub;
  logic                ge;
  logic [ValW:0]       fin_sum;

  assign diff_w    = {req_i.b[ValW-1], req_i.b} - {req_i.a[ValW-1], req_i.a};
  assign diff_neg  = '0 - diff_q;
  assign n_neg     = '0 - req_i.n;
  assign d_neg     = '0 - req_i.d;
  assign n_abs     = req_i.n[NdW-1] ? n_neg[MagnW-1:0] : req_i.n[MagnW-1:0];
  assign d_abs     = req_i.d[NdW-1] ? d_neg[MagnW-1:0] : req_i.d[MagnW-1:0];
  assign hi        = {1'b0, prod_q[ProdW-1:MagnW]} + (prod_q[0] ? {1'b0, uf_q} : '0);
  assign trial     = {rem_q, prod_q[ProdW-1]};
  assign trial_sub = trial - {1'b0, ud_q};
  assign ge        = (trial >= {1'b0, ud_q});
  assign fin_sum   = neg_q ? ({a_q[ValW-1], a_q} - {2'b00, prod_q[UfW-1:0]})
                           : ({a_q[ValW-1], a_q} + {2'b00, prod_q[UfW-1:0]});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    diff_d  = diff_q;
    neg_d   = neg_q;
    ud_d    = ud_q;
    uf_d    = uf_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    res_d   = res_q;
    case (state_q)
      IU_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          diff_d  = diff_w;
          neg_d   = req_i.n[NdW-1] ^ diff_w[ValW] ^ req_i.d[NdW-1];
          ud_d    = d_abs;
          prod_d  = {{UfW{1'b0}}, n_abs};
          state_d = IU_ABS;
        end
      end
      IU_ABS: begin
        uf_d    = diff_q[ValW] ? diff_neg[UfW-1:0] : diff_q[UfW-1:0];
        cnt_d   = '0;
        state_d = IU_MUL;
      end
      IU_MUL: begin
        prod_d = {hi, prod_q[MagnW-1:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(MulSteps - 1)) begin
          cnt_d   = '0;
          state_d = IU_BIAS;
        end
      end
      IU_BIAS: begin
        prod_d  = prod_q + ProdW'(ud_q >> 1);
        rem_d   = '0;
        state_d = IU_DIV;
      end
      IU_DIV: begin
        rem_d  = ge ? trial_sub[MagnW-1:0] : trial[MagnW-1:0];
        prod_d = {prod_q[ProdW-2:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = IU_FIN;
        end
      end
      IU_FIN: begin
        res_d   = fin_sum[ValW-1:0];
        done_d  = 1'b1;
        state_d = IU_IDLE;
      end
      default: state_d = IU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    diff_q <= diff_d;
    neg_q  <= neg_d;
    ud_q   <= ud_d;
    uf_q   <= uf_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = (state_q != IU_IDLE);
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/bode_stability_margin_scan.sv =====
// Channel   Dir  Beat payload
// s_axis    in   tdata: freq_hz, mag_db, phase_deg_in; tlast: last_point
// m_axis    out  tdata: freq/margin pairs; tuser: found flags; one beat per sweep
//
// A point with no new crossing is accepted, then evaluated and committed.
// Each crossing runs two interpolations on the shared bit-serial unit, each
// made of setup, 20 multiply steps, 60 divide steps and finish.
// Reset returns the scan to the start of a sweep with no result pending.
// A last point waits in commit while the previous result beat is unaccepted.
`include "bode_stability_margin_scan_macros.svh"

module bode_stability_margin_scan import bsms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [39:0] freq_hz, [56:40] mag_db, [76:57] phase_deg_in, [79:77] zero
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [39:0] gain_cross_freq, [59:40] phase_margin, [99:60] phase_cross_freq,
  // [116:100] gain_margin, [119:117] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // [0] gain_cross_found, [1] phase_cross_found
  output logic [OutTuserW-1:0] m_axis_tuser_o
);

  bsms_state_e state_q, state_d;

  logic [FreqW-1:0]     cur_freq_q, prev_freq_q;
  logic [MagW-1:0]      cur_mag_q, prev_mag_q;
  logic [PhaseW-1:0]    cur_phase_q, prev_phase_q;
  logic                 cur_last_q;
  logic                 have_prev_q;
  logic                 gain_done_q;
  logic                 phase_done_q;
  logic [FreqW-1:0]     held_gain_freq_q;
  logic [PhaseW-1:0]    held_pm_q;
  logic [FreqW-1:0]     held_phase_freq_q;
  logic [MagW-1:0]      held_gm_q;
  logic                 m_valid_q;
  logic [OutTdataW-1:0] out_tdata_q;
  logic [OutTuserW-1:0] out_tuser_q;

  logic                 s_hs;
  logic                 out_free;
  logic                 gx;
  logic                 px;
  logic                 p1_ge;
  logic                 p2_ge;
  logic [NdW-1:0]       g_n;
  logic [NdW-1:0]       g_d;
  logic [NdW-1:0]       p_n;
  logic [NdW-1:0]       p_d;
  logic                 start_job;
  logic                 commit_now;
  logic                 commit_prev;
  logic                 load_out;
  logic [PmWideW-1:0]   pm_wide;
  logic [PhaseW-1:0]    pm_sat;
  logic [GmWideW-1:0]   gm_wide;
  logic [MagW-1:0]      gm_sat;

  bsms_iu_req_t         iu_req;
  bsms_iu_stat_t        iu_stat;
  logic [ValW-1:0]      iu_res;

  bsms_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iu_req),
    .stat_o (iu_stat),
    .res_o  (iu_res)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign p1_ge = ($signed(prev_phase_q) >= $signed(PhaseThresh));
  assign p2_ge = ($signed(cur_phase_q) >= $signed(PhaseThresh));
  assign gx    = have_prev_q && !gain_done_q && (prev_mag_q[MagW-1] != cur_mag_q[MagW-1]);
  assign px    = have_prev_q && !phase_done_q && (p1_ge != p2_ge);

  assign g_n = '0 - {{(NdW-MagW){prev_mag_q[MagW-1]}}, prev_mag_q};
  assign g_d = {{(NdW-MagW){cur_mag_q[MagW-1]}}, cur_mag_q}
             - {{(NdW-MagW){prev_mag_q[MagW-1]}}, prev_mag_q};
  assign p_n = {PhaseThresh[PhaseW-1], PhaseThresh}
             - {prev_phase_q[PhaseW-1], prev_phase_q};
  assign p_d = {cur_phase_q[PhaseW-1], cur_phase_q}
             - {prev_phase_q[PhaseW-1], prev_phase_q};

  // Saturate phase + 180 and negated magnitude to the result widths.
  assign pm_wide = {{(PmWideW-PhaseW){iu_res[PhaseW-1]}}, iu_res[PhaseW-1:0]} + PhaseOffset;
  assign gm_wide = '0 - {iu_res[MagW-1], iu_res[MagW-1:0]};

  always_comb begin
    if (pm_wide[PmWideW-1:PhaseW-1] == '0 || pm_wide[PmWideW-1:PhaseW-1] == '1) begin
      pm_sat = pm_wide[PhaseW-1:0];
    end else if (pm_wide[PmWideW-1]) begin
      pm_sat = {1'b1, {(PhaseW-1){1'b0}}};
    end else begin
      pm_sat = {1'b0, {(PhaseW-1){1'b1}}};
    end
    if (gm_wide[GmWideW-1] == gm_wide[MagW-1]) begin
      gm_sat = gm_wide[MagW-1:0];
    end else if (gm_wide[GmWideW-1]) begin
      gm_sat = {1'b1, {(MagW-1){1'b0}}};
    end else begin
      gm_sat = {1'b0, {(MagW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d     = state_q;
    start_job   = 1'b0;
    commit_now  = 1'b0;
    commit_prev = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (gx) begin
          state_d   = ST_G_FREQ;
          start_job = 1'b1;
        end else if (px) begin
          state_d   = ST_P_FREQ;
          start_job = 1'b1;
        end else begin
          commit_now = 1'b1;
        end
      end
      ST_G_FREQ: begin
        if (iu_stat.done) begin
          state_d   = ST_G_PH;
          start_job = 1'b1;
        end
      end
      ST_G_PH: begin
        if (iu_stat.done) begin
          if (px) begin
            state_d   = ST_P_FREQ;
            start_job = 1'b1;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_P_FREQ: begin
        if (iu_stat.done) begin
          state_d   = ST_P_MAG;
          start_job = 1'b1;
        end
      end
      ST_P_MAG: begin
        if (iu_stat.done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        commit_now = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    if (commit_now) begin
      if (!cur_last_q) begin
        commit_prev = 1'b1;
        state_d     = ST_IDLE;
      end else if (out_free) begin
        load_out = 1'b1;
        state_d  = ST_IDLE;
      end
    end
  end

  always_comb begin
    iu_req.start = start_job;
    case (state_d)
      ST_G_FREQ: begin
        iu_req.a = {1'b0, prev_freq_q};
        iu_req.b = {1'b0, cur_freq_q};
        iu_req.n = g_n;
        iu_req.d = g_d;
      end
      ST_G_PH: begin
        iu_req.a = {{(ValW-PhaseW){prev_phase_q[PhaseW-1]}}, prev_phase_q};
        iu_req.b = {{(ValW-PhaseW){cur_phase_q[PhaseW-1]}}, cur_phase_q};
        iu_req.n = g_n;
        iu_req.d = g_d;
      end
      ST_P_FREQ: begin
        iu_req.a = {1'b0, prev_freq_q};
        iu_req.b = {1'b0, cur_freq_q};
        iu_req.n = p_n;
        iu_req.d = p_d;
      end
      ST_P_MAG: begin
        iu_req.a = {{(ValW-MagW){prev_mag_q[MagW-1]}}, prev_mag_q};
        iu_req.b = {{(ValW-MagW){cur_mag_q[MagW-1]}}, cur_mag_q};
        iu_req.n = p_n;
        iu_req.d = p_d;
      end
      default: begin
        iu_req.a = '0;
        iu_req.b = '0;
        iu_req.n = '0;
        iu_req.d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      have_prev_q  <= 1'b0;
      gain_done_q  <= 1'b0;
      phase_done_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_prev) begin
        have_prev_q <= 1'b1;
      end
      if (iu_stat.done && state_q == ST_G_PH) begin
        gain_done_q <= 1'b1;
      end
      if (iu_stat.done && state_q == ST_P_MAG) begin
        phase_done_q <= 1'b1;
      end
      if (load_out) begin
        have_prev_q  <= 1'b0;
        gain_done_q  <= 1'b0;
        phase_done_q <= 1'b0;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      cur_freq_q  <= s_axis_tdata_i[FreqW-1:0];
      cur_mag_q   <= s_axis_tdata_i[FreqW+MagW-1:FreqW];
      cur_phase_q <= s_axis_tdata_i[FreqW+MagW+PhaseW-1:FreqW+MagW];
      cur_last_q  <= s_axis_tlast_i;
    end
    if (commit_prev) begin
      prev_freq_q  <= cur_freq_q;
      prev_mag_q   <= cur_mag_q;
      prev_phase_q <= cur_phase_q;
    end
    if (iu_stat.done) begin
      case (state_q)
        ST_G_FREQ: held_gain_freq_q  <= iu_res[FreqW-1:0];
        ST_G_PH:   held_pm_q         <= pm_sat;
        ST_P_FREQ: held_phase_freq_q <= iu_res[FreqW-1:0];
        ST_P_MAG:  held_gm_q         <= gm_sat;
        default: ;
      endcase
    end
    if (load_out) begin
      out_tdata_q <= {{(OutTdataW-2*FreqW-PhaseW-MagW){1'b0}},
                      phase_done_q ? held_gm_q : {MagW{1'b0}},
                      phase_done_q ? held_phase_freq_q : {FreqW{1'b0}},
                      gain_done_q ? held_pm_q : {PhaseW{1'b0}},
                      gain_done_q ? held_gain_freq_q : {FreqW{1'b0}}};
      out_tuser_q <= {phase_done_q, gain_done_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;

  `BSMS_ASSERT_IMPL(a_accept_unit_idle, clk_i, rst_ni, s_hs, !iu_stat.busy)
  `BSMS_ASSERT_IMPL(a_done_in_job, clk_i, rst_ni, iu_stat.done,
    state_q == ST_G_FREQ || state_q == ST_G_PH || state_q == ST_P_FREQ || state_q == ST_P_MAG)
  `BSMS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, load_out,
    m_valid_q && !have_prev_q && !gain_done_q && !phase_done_q)

endmodule
